// ===== sv/mp2d_pkg.sv =====
// package for the streaming 2-d max pooling block
// shared constants, controller states and window axis helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mp2d_pkg;
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 1024;
	localparam int DEF_MAX_POOL    = 8;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int CW              = 16;
	localparam int POOLED_BITS     = 16;
	localparam int COORD_BITS      = 10;
	localparam int ADDR_BITS       = 5;

	localparam logic [2:0] REG_IN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH  = 3'd1;
	localparam logic [2:0] REG_POOL_H    = 3'd2;
	localparam logic [2:0] REG_POOL_W    = 3'd3;
	localparam logic [2:0] REG_STRIDE_H  = 3'd4;
	localparam logic [2:0] REG_STRIDE_W  = 3'd5;
	localparam logic [2:0] REG_PAD_H     = 3'd6;
	localparam logic [2:0] REG_PAD_W     = 3'd7;

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_WAIT,
		ST_EMIT,
		ST_FINISH,
		ST_ROWADV
	} state_t;

	// window whose origin base (o*stride) ends its last real position at p
	function automatic logic axis_hit(coord_t base, coord_t pad, coord_t pool,
		coord_t size, coord_t p);
		coord_t span;
		coord_t last;
		span = size + pad + pad - pool;
		last = base - pad + pool - coord_t'(1);
		if (last > size - coord_t'(1))
			last = size - coord_t'(1);
		return (span >= 0) && (base <= span) && (last == p);
	endfunction

	// last window on the axis
	function automatic logic axis_end(coord_t base, coord_t stride, coord_t pad,
		coord_t pool, coord_t size);
		coord_t span;
		span = size + pad + pad - pool;
		return base + stride > span;
	endfunction
endpackage
`default_nettype wire

// ===== sv/mp2d_if.sv =====
// stream channel interfaces: input samples and pooled results
// depends on mp2d_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface mp2d_in_if import mp2d_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mp2d_out_if import mp2d_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [POOLED_BITS-1:0] pooled;
	logic [COORD_BITS-1:0]         out_row;
	logic [COORD_BITS-1:0]         out_col;
	logic                          channel_done;
	logic                          run_last;
	modport source (output valid, output pooled, output out_row, output out_col,
		output channel_done, output run_last, input ready);
	modport sink (input valid, input pooled, input out_row, input out_col,
		input channel_done, input run_last, output ready);
endinterface
`default_nettype wire

// ===== sv/max_pool_2d_top.sv =====
// streaming 2-d max pooling top level: apb registers, window sequencer, line store
// depends on mp2d_pkg, mp2d_if and mp2d_ram
//
// channel   dir  handshake          payload
// in_ch     in   valid/ready        sample
// out_ch    out  valid/ready        pooled, out_row, out_col, channel_done, run_last
// apb       in   psel/penable       paddr, pwdata, prdata
//
// a sample that finishes no window passes through accept, check and finish
// each result reads its real window area, then waits and emits, after a further check if not the first
// each column window ending at the sample is stepped past in the finish state
// a row end goes through the row advance state, which steps past each row window ending on that row
// reset clears control state; the line store holds no reset value
// a stalled result holds the sequencer, no sample is taken while results are pending
`timescale 1ns / 1ps
`default_nettype none
module max_pool_2d_top import mp2d_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_POOL    = DEF_MAX_POOL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mp2d_in_if.sink                   in_ch,
	mp2d_out_if.source                out_ch,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output      logic [31:0]          prdata,
	output      logic                 pready
);
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int PW      = $clog2(MAX_DIM);
	localparam int SLW     = $clog2(MAX_POOL);
	localparam int DEPTH   = MAX_POOL * MAX_WIDTH;
	localparam int AW      = $clog2(DEPTH);

	logic [10:0] in_height_q, in_width_q;
	logic [3:0]  pool_h_q, pool_w_q, stride_h_q, stride_w_q;
	logic [2:0]  pad_h_q, pad_w_q;

	coord_t h_e, w_e, ph_e, pw_e, sh_e, sw_e, padh_e, padw_e;

	state_t state_q, state_d;

	logic [PW-1:0]  x_q, y_q;
	logic [SLW-1:0] ys_q;
	logic [PW:0]    ro_q, co_q, ra_q, cb_q;
	coord_t         rbase_q, cbase_q, rb_q, cbs_q;
	logic [PW-1:0]  rd_x_q, rd_y_q;
	logic           rdv_s1;
	logic signed [SAMPLE_BITS-1:0] m_q;
	logic [SAMPLE_BITS-1:0]        rdata;

	logic   cfg_wr, in_acc, out_acc;
	logic   row_hit, col_hit, col_next, row_next, col_adv, row_adv;
	coord_t xc, yc, rlo, clo;
	logic   rd_last;
	logic [PW-1:0]  row_back;
	logic [SLW-1:0] slot;
	logic [AW-1:0]  waddr, raddr;
	logic signed [31:0] mx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q <= 11'd1;
			in_width_q  <= 11'd1;
			pool_h_q    <= 4'd2;
			pool_w_q    <= 4'd2;
			stride_h_q  <= 4'd2;
			stride_w_q  <= 4'd2;
			pad_h_q     <= 3'd0;
			pad_w_q     <= 3'd0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_IN_HEIGHT: in_height_q <= pwdata[10:0];
				REG_IN_WIDTH:  in_width_q  <= pwdata[10:0];
				REG_POOL_H:    pool_h_q    <= pwdata[3:0];
				REG_POOL_W:    pool_w_q    <= pwdata[3:0];
				REG_STRIDE_H:  stride_h_q  <= pwdata[3:0];
				REG_STRIDE_W:  stride_w_q  <= pwdata[3:0];
				REG_PAD_H:     pad_h_q     <= pwdata[2:0];
				REG_PAD_W:     pad_w_q     <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_IN_HEIGHT: prdata = 32'(in_height_q);
			REG_IN_WIDTH:  prdata = 32'(in_width_q);
			REG_POOL_H:    prdata = 32'(pool_h_q);
			REG_POOL_W:    prdata = 32'(pool_w_q);
			REG_STRIDE_H:  prdata = 32'(stride_h_q);
			REG_STRIDE_W:  prdata = 32'(stride_w_q);
			REG_PAD_H:     prdata = 32'(pad_h_q);
			REG_PAD_W:     prdata = 32'(pad_w_q);
		endcase
	end

	// clamped working values
	always_comb begin
		h_e = coord_t'(in_height_q);
		if (h_e == 0) h_e = coord_t'(1);
		if (h_e > coord_t'(MAX_HEIGHT)) h_e = coord_t'(MAX_HEIGHT);
		w_e = coord_t'(in_width_q);
		if (w_e == 0) w_e = coord_t'(1);
		if (w_e > coord_t'(MAX_WIDTH)) w_e = coord_t'(MAX_WIDTH);
		ph_e = coord_t'(pool_h_q);
		if (ph_e == 0) ph_e = coord_t'(1);
		if (ph_e > coord_t'(MAX_POOL)) ph_e = coord_t'(MAX_POOL);
		pw_e = coord_t'(pool_w_q);
		if (pw_e == 0) pw_e = coord_t'(1);
		if (pw_e > coord_t'(MAX_POOL)) pw_e = coord_t'(MAX_POOL);
		sh_e = (stride_h_q == 4'd0) ? coord_t'(1) : coord_t'(stride_h_q);
		sw_e = (stride_w_q == 4'd0) ? coord_t'(1) : coord_t'(stride_w_q);
		padh_e = coord_t'(pad_h_q);
		if (padh_e > (ph_e >>> 1)) padh_e = ph_e >>> 1;
		padw_e = coord_t'(pad_w_q);
		if (padw_e > (pw_e >>> 1)) padw_e = pw_e >>> 1;
	end

	assign xc       = coord_t'(x_q);
	assign yc       = coord_t'(y_q);
	assign row_hit  = axis_hit(rb_q, padh_e, ph_e, h_e, yc);
	assign row_next = axis_hit(rb_q + sh_e, padh_e, ph_e, h_e, yc);
	assign col_hit  = axis_hit(cbs_q, padw_e, pw_e, w_e, xc);
	assign col_next = axis_hit(cbs_q + sw_e, padw_e, pw_e, w_e, xc);
	assign col_adv  = axis_hit(cbase_q, padw_e, pw_e, w_e, xc);
	assign row_adv  = axis_hit(rbase_q, padh_e, ph_e, h_e, yc);

	always_comb begin
		rlo = rb_q - padh_e;
		if (rlo < 0) rlo = '0;
		clo = cbs_q - padw_e;
		if (clo < 0) clo = '0;
	end

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign rd_last = (rd_x_q == x_q) && (rd_y_q == y_q);

	// line store slot of a window row, counted back from the current row
	always_comb begin
		row_back = y_q - rd_y_q;
		if (32'(ys_q) >= 32'(row_back))
			slot = SLW'(32'(ys_q) - 32'(row_back));
		else
			slot = SLW'(32'(ys_q) + MAX_POOL - 32'(row_back));
	end
	assign raddr = AW'(32'(slot) * MAX_WIDTH + 32'(rd_x_q));
	assign waddr = AW'(32'(ys_q) * MAX_WIDTH + 32'(x_q));

	mp2d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_line (
		.clk   (clk),
		.we    (in_acc),
		.waddr (waddr),
		.wdata (in_ch.sample),
		.re    (state_q == ST_READ),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_ch.valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = (row_hit && col_hit) ? ST_READ : ST_FINISH;
			ST_READ:   if (rd_last) state_d = ST_WAIT;
			ST_WAIT:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ch.ready)
					state_d = (col_next || row_next) ? ST_CHECK : ST_FINISH;
			end
			ST_FINISH: begin
				if (!col_adv)
					state_d = (x_q == PW'(w_e - coord_t'(1))) ? ST_ROWADV : ST_IDLE;
			end
			ST_ROWADV: begin
				if ((y_q == PW'(h_e - coord_t'(1))) || !row_adv)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= (state_q == ST_READ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			ys_q    <= '0;
			ro_q    <= '0;
			co_q    <= '0;
			rbase_q <= '0;
			cbase_q <= '0;
		end else if (cfg_wr) begin
			x_q     <= '0;
			y_q     <= '0;
			ys_q    <= '0;
			ro_q    <= '0;
			co_q    <= '0;
			rbase_q <= '0;
			cbase_q <= '0;
		end else if (state_q == ST_FINISH) begin
			if (col_adv) begin
				co_q    <= co_q + 1'b1;
				cbase_q <= cbase_q + sw_e;
			end else if (x_q != PW'(w_e - coord_t'(1))) begin
				x_q <= x_q + 1'b1;
			end
		end else if (state_q == ST_ROWADV) begin
			if (y_q == PW'(h_e - coord_t'(1))) begin
				x_q     <= '0;
				co_q    <= '0;
				cbase_q <= '0;
				y_q     <= '0;
				ys_q    <= '0;
				ro_q    <= '0;
				rbase_q <= '0;
			end else if (row_adv) begin
				ro_q    <= ro_q + 1'b1;
				rbase_q <= rbase_q + sh_e;
			end else begin
				x_q     <= '0;
				co_q    <= '0;
				cbase_q <= '0;
				y_q     <= y_q + 1'b1;
				ys_q    <= (32'(ys_q) == MAX_POOL - 1) ? '0 : ys_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_s1 && (signed'(rdata) > m_q))
			m_q <= signed'(rdata);
		unique case (state_q)
			ST_IDLE: begin
				ra_q  <= ro_q;
				rb_q  <= rbase_q;
				cb_q  <= co_q;
				cbs_q <= cbase_q;
			end
			ST_CHECK: begin
				m_q    <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
				rd_y_q <= PW'(rlo);
				rd_x_q <= PW'(clo);
			end
			ST_READ: begin
				if (rd_x_q == x_q) begin
					rd_x_q <= PW'(clo);
					rd_y_q <= rd_y_q + 1'b1;
				end else begin
					rd_x_q <= rd_x_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_ch.ready) begin
					if (col_next) begin
						cb_q  <= cb_q + 1'b1;
						cbs_q <= cbs_q + sw_e;
					end else if (row_next) begin
						ra_q  <= ra_q + 1'b1;
						rb_q  <= rb_q + sh_e;
						cb_q  <= co_q;
						cbs_q <= cbase_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign mx = 32'(m_q);
	always_comb begin
		out_ch.pooled       = mx[POOLED_BITS-1:0];
		out_ch.out_row      = ra_q[COORD_BITS-1:0];
		out_ch.out_col      = cb_q[COORD_BITS-1:0];
		out_ch.channel_done = axis_end(rb_q, sh_e, padh_e, ph_e, h_e)
			&& axis_end(cbs_q, sw_e, padw_e, pw_e, w_e);
		out_ch.run_last     = !col_next && !row_next;
	end

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("sample taken while a result is pending");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.channel_done |-> out_ch.run_last)
		else $error("channel end without end of run");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_ch.run_last |=> !out_ch.valid && !in_ch.ready)
		else $error("run did not close after its last result");
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		coord_t'(x_q) < w_e || $past(cfg_wr))
		else $error("column position beyond width");
endmodule
`default_nettype wire

// ===== sv/mp2d_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mp2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the streaming 2-d max pooling block
// drives raster samples and apb register writes, predicts every pooled window and checks it
// depends on mp2d_pkg, mp2d_if and max_pool_2d_top
`timescale 1ns / 1ps
module tb_top;
	import mp2d_pkg::*;

	localparam int MAXW       = 1024;
	localparam int MAXH       = 1024;
	localparam int MAXP       = 8;
	localparam int TAIL       = 400;
	localparam int CYCLE_CAP  = 3000000;
	localparam int RAND_ITEMS = 30;

	typedef struct {
		logic signed [15:0] pooled;
		logic [9:0]         out_row;
		logic [9:0]         out_col;
		logic               channel_done;
		logic               run_last;
	} window_max_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	mp2d_in_if in_ch();
	mp2d_out_if out_ch();

	max_pool_2d_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [10:0] cfg_reg [0:7];
	logic signed [15:0] row_mem [0:MAXP*MAXW-1];
	int row_at, col_at;
	window_max_t windows_due[$];

	int errors = 0;
	int samples_sent = 0;
	int windows_seen = 0;
	int cycles = 0;
	bit no_idle = 0;
	int rx_hold = 0;
	int rx_stall = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int clampi(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int axis_count(int size, int pool, int stride, int pad);
		int span;
		span = size + 2 * pad - pool;
		if (span < 0) return 0;
		return span / stride + 1;
	endfunction

	task automatic axis_hits(input int p, input int size, input int pool, input int stride,
		input int pad, output int n, output int idx[MAXP], output int lo[MAXP],
		output int hi[MAXP]);
		int cnt, first, last;
		n = 0;
		cnt = axis_count(size, pool, stride, pad);
		for (int o = 0; o < cnt && n < MAXP; o++) begin
			first = o * stride - pad;
			last = first + pool - 1;
			if (first < 0) first = 0;
			if (last > size - 1) last = size - 1;
			if (last == p) begin
				idx[n] = o;
				lo[n] = first;
				hi[n] = last;
				n++;
			end
		end
	endtask

	function automatic int eff_height();
		return clampi(cfg_reg[REG_IN_HEIGHT], 1, MAXH);
	endfunction

	function automatic int eff_width();
		return clampi(cfg_reg[REG_IN_WIDTH], 1, MAXW);
	endfunction

	task automatic pool_predict(input logic signed [15:0] s);
		int h, w, ph, pw, sh, sw, padh, padw, oh, ow, nr, nc, m;
		int ri[MAXP], rlo[MAXP], rhi[MAXP], ci[MAXP], clo[MAXP], chi[MAXP];
		window_max_t wm;
		window_max_t burst[$];
		h = eff_height();
		w = eff_width();
		ph = clampi(cfg_reg[REG_POOL_H], 1, MAXP);
		pw = clampi(cfg_reg[REG_POOL_W], 1, MAXP);
		sh = clampi(cfg_reg[REG_STRIDE_H], 1, 15);
		sw = clampi(cfg_reg[REG_STRIDE_W], 1, 15);
		padh = clampi(cfg_reg[REG_PAD_H], 0, ph / 2);
		padw = clampi(cfg_reg[REG_PAD_W], 0, pw / 2);
		if (row_at >= h) row_at = 0;
		if (col_at >= w) col_at = 0;
		row_mem[(row_at % MAXP) * MAXW + col_at] = s;
		oh = axis_count(h, ph, sh, padh);
		ow = axis_count(w, pw, sw, padw);
		axis_hits(row_at, h, ph, sh, padh, nr, ri, rlo, rhi);
		axis_hits(col_at, w, pw, sw, padw, nc, ci, clo, chi);
		for (int a = 0; a < nr; a++)
			for (int b = 0; b < nc; b++) begin
				m = 32'sh80000000;
				for (int yy = rlo[a]; yy <= rhi[a]; yy++)
					for (int xx = clo[b]; xx <= chi[b]; xx++)
						if (int'(row_mem[(yy % MAXP) * MAXW + xx]) > m)
							m = row_mem[(yy % MAXP) * MAXW + xx];
				wm.pooled = m[15:0];
				wm.out_row = ri[a][9:0];
				wm.out_col = ci[b][9:0];
				wm.channel_done = (ri[a] + 1 == oh) && (ci[b] + 1 == ow);
				wm.run_last = 0;
				burst.push_back(wm);
			end
		if (burst.size() > 0) burst[burst.size() - 1].run_last = 1;
		foreach (burst[i]) windows_due.push_back(burst[i]);
		col_at++;
		if (col_at >= w) begin
			col_at = 0;
			row_at++;
			if (row_at >= h) row_at = 0;
		end
	endtask

	// all tasks below start and end at a falling edge
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= ADDR_BITS'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg_reg[idx] = 11'(value[10:0] & ((11'd1 << ((idx < 2) ? 11 : (idx < 6) ? 4 : 3)) - 1));
		row_at = 0;
		col_at = 0;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_geometry(input int h, input int w, input int ph, input int pw,
		input int sh, input int sw, input int pdh, input int pdw);
		apb_write(REG_IN_HEIGHT, h);
		apb_write(REG_IN_WIDTH, w);
		apb_write(REG_POOL_H, ph);
		apb_write(REG_POOL_W, pw);
		apb_write(REG_STRIDE_H, sh);
		apb_write(REG_STRIDE_W, sw);
		apb_write(REG_PAD_H, pdh);
		apb_write(REG_PAD_W, pdw);
	endtask

	task automatic send_sample(input logic signed [15:0] s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.sample <= s;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pool_predict(s);
		samples_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_channel();
		int n;
		n = eff_height() * eff_width();
		repeat (n) send_sample(pick_sample());
	endtask

	task automatic wait_idle();
		in_ch.valid <= 0;
		while (windows_due.size() != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	// receiver: random stalls plus an optional long hold
	initial begin
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ch.ready <= 0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				out_ch.ready <= 0;
				rx_stall--;
			end else
				out_ch.ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			window_max_t e;
			windows_seen++;
			rx_stall = no_idle ? 0 : $urandom_range(0, 19);
			if (windows_due.size() == 0) begin
				$error("unexpected transaction pooled=%0d row=%0d col=%0d",
					out_ch.pooled, out_ch.out_row, out_ch.out_col);
				errors++;
			end else begin
				e = windows_due.pop_front();
				if (out_ch.pooled !== e.pooled) begin
					$error("pooled expected %0d actual %0d", e.pooled, out_ch.pooled);
					errors++;
				end
				if (out_ch.out_row !== e.out_row) begin
					$error("out_row expected %0d actual %0d", e.out_row, out_ch.out_row);
					errors++;
				end
				if (out_ch.out_col !== e.out_col) begin
					$error("out_col expected %0d actual %0d", e.out_col, out_ch.out_col);
					errors++;
				end
				if (out_ch.channel_done !== e.channel_done) begin
					$error("channel_done expected %0d actual %0d", e.channel_done,
						out_ch.channel_done);
					errors++;
				end
				if (out_ch.run_last !== e.run_last) begin
					$error("run_last expected %0d actual %0d", e.run_last, out_ch.run_last);
					errors++;
				end
			end
		end
	end

	// reset values give no window at all
	task automatic test_reset_state();
		repeat (3) send_sample(pick_sample());
		wait_idle();
	endtask

	task automatic test_directed_windows();
		logic signed [15:0] edge_vals [4];
		edge_vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		set_geometry(4, 4, 2, 2, 2, 2, 0, 0);
		for (int i = 0; i < 16; i++) send_sample(edge_vals[i % 4]);
		wait_idle();
		// overlapping windows with padding, several results per sample
		set_geometry(3, 3, 3, 3, 1, 1, 1, 1);
		repeat (9) send_sample(16'sh8000 + 16'($urandom_range(0, 3)));
		wait_idle();
		// zero registers act as one
		set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		wait_idle();
		// window larger than the image, nothing comes out
		set_geometry(2, 2, 8, 3, 1, 1, 0, 0);
		send_channel();
		wait_idle();
	endtask

	task automatic test_saturation_limits();
		// oversized pool and pad saturate, stride at its largest value
		set_geometry(5, 5, 15, 15, 15, 15, 7, 7);
		send_channel();
		wait_idle();
		// oversized width and height, first windows only
		set_geometry(1, 2047, 8, 8, 8, 8, 4, 4);
		no_idle = 1;
		repeat (12) send_sample(pick_sample());
		wait_idle();
		set_geometry(2047, 1, 8, 1, 8, 1, 4, 0);
		repeat (12) send_sample(pick_sample());
		no_idle = 0;
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_geometry(6, 6, 2, 2, 1, 1, 1, 1);
		no_idle = 1;
		rx_hold = 600;
		send_channel();
		no_idle = 0;
		wait_idle();
	endtask

	task automatic test_random_geometry();
		int start;
		start = samples_sent;
		while (samples_sent - start < RAND_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			set_geometry($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 8),
				$urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
				$urandom_range(0, 7), $urandom_range(0, 7));
			repeat ($urandom_range(1, 2)) send_channel();
			wait_idle();
		end
		no_idle = 0;
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 0;
		in_ch.sample = '0;
		cfg_reg = '{11'd1, 11'd1, 11'd2, 11'd2, 11'd2, 11'd2, 11'd0, 11'd0};
		row_at = 0;
		col_at = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_reset_state();
		test_directed_windows();
		test_saturation_limits();
		test_backpressure();
		test_random_geometry();
		$display("covered %0d samples and %0d pooled windows over many geometries",
			samples_sent, windows_seen);
		$display("including padding, saturated registers, empty channels and long stalls");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== max_pool_2d_top.f =====
sv/mp2d_pkg.sv
sv/mp2d_if.sv
sv/mp2d_ram.sv
sv/max_pool_2d_top.sv
tb/sv/tb_top.sv
